// ----- sv/tle_pkg.sv -----
// tle_pkg: sizes, command codes and controller/datapath handshake structs
// for the timer list tick expiry block; no dependencies
`default_nettype none

package tle_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int TIME_BITS  = 32;

  // slots a tick visits: only slots below 16 can ever be addressed
  localparam int SLOT_SPAN = (NUM_TIMERS < 16) ? NUM_TIMERS : 16;
  localparam int SLOT_BITS = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_BITS  = (SLOT_SPAN > 1) ? $clog2(SLOT_SPAN) : 1;
  // widths that hold both a field and its internal counterpart
  localparam int SEL_BITS  = (SLOT_BITS > 4) ? SLOT_BITS : 4;
  localparam int IVL_BITS  = (TIME_BITS > 32) ? TIME_BITS : 32;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  typedef logic [TIME_BITS-1:0] time_t;

  // controller to datapath
  typedef struct packed {
    logic start;   // tick accepted: rewind the slot sweep
    logic add;     // add or restart beat accepted
    logic remove;  // remove beat accepted
    logic step;    // process the current slot and advance
    logic flush;   // hand the held result out as the final one
  } tle_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;         // current slot expires on this tick
    logic scan_last;   // current slot is the last one of the sweep
    logic pend_valid;  // a result is held back awaiting its last flag
    logic out_free;    // output register can take a beat this cycle
  } tle_stat_t;

endpackage

`default_nettype wire

// ----- sv/tle_if.sv -----
// tle_in_if / tle_out_if: valid-ready channels for commands and expiry results
// depends on tle_pkg for nothing but the command encoding convention
`default_nettype none

interface tle_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [3:0]  slot;
  logic [31:0] interval;
  logic        one_shot;

  modport source (output valid, command, slot, interval, one_shot, input ready);
  modport sink   (input valid, command, slot, interval, one_shot, output ready);
endinterface

interface tle_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] expired_slot;
  logic       deactivated;
  logic       last;

  modport source (output valid, expired_slot, deactivated, last, input ready);
  modport sink   (input valid, expired_slot, deactivated, last, output ready);
endinterface

`default_nettype wire

// ----- sv/tle_ctrl.sv -----
// tle_ctrl: sequencer for command decode, the per-tick slot sweep and the
// final flush; depends on tle_pkg
`default_nettype none

module tle_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic [1:0]         in_command,
  output logic                    in_ready,
  input  wire tle_pkg::tle_stat_t stat,
  output tle_pkg::tle_cmd_t       cmd
);
  import tle_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;
  logic   stall;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  // a second expiry cannot move the held result while the output is full
  assign stall    = stat.hit && stat.pend_valid && !stat.out_free;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_command)
            CMD_TICK: begin
              cmd.start = 1'b1;
              state_nxt = ST_SCAN;
            end
            CMD_ADD:    cmd.add = 1'b1;
            CMD_REMOVE: cmd.remove = 1'b1;
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          cmd.step = 1'b1;
          if (stat.scan_last) state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!stat.pend_valid) begin
          state_nxt = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // a tick always reaches the sweep on the following cycle
  a_tick_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> (state_r == ST_SCAN))
    else $error("tick did not start the sweep");

  // the sweep never steps over a stalled expiry
  a_no_step_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && stat.hit && stat.pend_valid) |-> stat.out_free)
    else $error("sweep stepped while output was blocked");

endmodule

`default_nettype wire

// ----- sv/tle_dp.sv -----
// tle_dp: timer slot storage, sweep counter, held result and output register
// depends on tle_pkg; driven by tle_ctrl commands
`default_nettype none

module tle_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tle_pkg::tle_cmd_t  cmd,
  output tle_pkg::tle_stat_t      stat,
  input  wire logic [3:0]         in_slot,
  input  wire logic [31:0]        in_interval,
  input  wire logic               in_one_shot,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [3:0]              out_expired_slot,
  output logic                    out_deactivated,
  output logic                    out_last
);
  import tle_pkg::*;

  time_t                 time_left_r [NUM_TIMERS];
  time_t                 reload_r    [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] active_r;
  logic [NUM_TIMERS-1:0] once_r;

  logic [CNT_BITS-1:0]   cnt_r;
  logic                  pend_valid_r;
  logic [3:0]            pend_slot_r;
  logic                  pend_deact_r;
  logic                  out_valid_r;
  logic [3:0]            out_slot_r;
  logic                  out_deact_r;
  logic                  out_last_r;

  logic [SEL_BITS-1:0]   a_sel, c_sel;
  logic [SLOT_BITS-1:0]  aidx, cidx;
  logic [IVL_BITS-1:0]   ivl_ext;
  time_t                 load_val;
  logic                  in_range;
  time_t                 tl_cur, tl_dec;
  logic                  hit;
  logic                  push;

  assign a_sel    = SEL_BITS'(in_slot);
  assign aidx     = a_sel[SLOT_BITS-1:0];
  assign c_sel    = SEL_BITS'(cnt_r);
  assign cidx     = c_sel[SLOT_BITS-1:0];
  assign in_range = ({3'b000, in_slot} < 7'(NUM_TIMERS));
  assign ivl_ext  = IVL_BITS'(in_interval);
  assign load_val = ivl_ext[TIME_BITS-1:0];

  assign tl_cur = time_left_r[cidx];
  assign tl_dec = tl_cur - time_t'(1);
  assign hit    = active_r[cidx] && (tl_dec == '0);
  // a held result leaves either when a later expiry replaces it or at the end
  assign push   = pend_valid_r && ((cmd.step && hit) || cmd.flush);

  assign stat.hit        = hit;
  assign stat.scan_last  = (cnt_r == CNT_BITS'(SLOT_SPAN - 1));
  assign stat.pend_valid = pend_valid_r;
  assign stat.out_free   = !out_valid_r || out_ready;

  // slot payload, no reset: only read once an add has written it
  always_ff @(posedge clk) begin
    if (cmd.add && in_range) begin
      time_left_r[aidx] <= load_val;
      reload_r[aidx]    <= load_val;
      once_r[aidx]      <= in_one_shot;
    end else if (cmd.step && active_r[cidx]) begin
      time_left_r[cidx] <= (hit && !once_r[cidx]) ? reload_r[cidx] : tl_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= '0;
      cnt_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.add && in_range) begin
        active_r[aidx] <= 1'b1;
      end else if (cmd.remove && in_range) begin
        active_r[aidx] <= 1'b0;
      end else if (cmd.step && hit && once_r[cidx]) begin
        active_r[cidx] <= 1'b0;
      end

      if (cmd.start) begin
        cnt_r <= '0;
      end else if (cmd.step && !stat.scan_last) begin
        cnt_r <= cnt_r + CNT_BITS'(1);
      end

      if (cmd.start || cmd.flush) begin
        pend_valid_r <= 1'b0;
      end else if (cmd.step && hit) begin
        pend_valid_r <= 1'b1;
      end

      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && hit) begin
      pend_slot_r  <= 4'(cnt_r);
      pend_deact_r <= once_r[cidx];
    end
    if (push) begin
      out_slot_r  <= pend_slot_r;
      out_deact_r <= pend_deact_r;
      out_last_r  <= cmd.flush;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_expired_slot = out_slot_r;
  assign out_deactivated  = out_deact_r;
  assign out_last         = out_last_r;

  // a beat is never written over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (push && out_valid_r) |-> out_ready)
    else $error("output beat overwritten");

  // a tick starts with nothing held back
  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> (!pend_valid_r && cnt_r == '0))
    else $error("sweep not rewound");

  // an expiring one-shot slot is inactive afterwards
  a_one_shot_off: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && hit && once_r[cidx]) |=> !active_r[$past(cidx)])
    else $error("one-shot slot still active");

endmodule

`default_nettype wire

// ----- sv/timer_list_tick_expiry.sv -----
// timer_list_tick_expiry: top level of the tick driven timer slot bank
// depends on tle_pkg, tle_if, tle_ctrl and tle_dp
//
// usage
//   in_ch carries one command per beat: tick, add (load slot with interval
//   and one-shot mark, restart if already running) or remove (stop slot).
//   out_ch carries one beat per slot that expires on a tick, in ascending
//   slot order, with last set on the final beat of that tick. a tick with no
//   expiry, an add and a remove produce no beat.
// command handling
//   add and remove are done in the idle state, which keeps in_ch ready. a tick
//   sweeps one slot per cycle through the slot storage unless an expiry stalls on
//   the output, then releases the final result in the flush state, waiting there
//   for a free output register, before in_ch is ready again.
//   each expiry result is held back until the next expiry of the same tick
//   so its last flag is known; the final one leaves in the flush cycle.
// reset
//   rst_n low at a clock edge marks every slot inactive and empties the output;
//   no clearing pass is needed.
// stalls
//   a waiting output beat does not block the sweep until a second expiry
//   needs the output register; the sweep then holds on that slot until
//   out_ch.ready is seen.
`default_nettype none

module timer_list_tick_expiry (
  input wire logic clk,
  input wire logic rst_n,
  tle_in_if.sink   in_ch,
  tle_out_if.source out_ch
);
  import tle_pkg::*;

  tle_cmd_t  cmd;   // sequencer commands into the datapath
  tle_stat_t stat;  // datapath status back to the sequencer

  // sequencer: decode, sweep and flush
  tle_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // slot storage and the two result registers
  tle_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_slot          (in_ch.slot),
    .in_interval      (in_ch.interval),
    .in_one_shot      (in_ch.one_shot),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_expired_slot (out_ch.expired_slot),
    .out_deactivated  (out_ch.deactivated),
    .out_last         (out_ch.last)
  );

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// tb_top: self-checking bench for timer_list_tick_expiry, with its own model of the slot bank
// depends on tle_pkg, tle_in_if / tle_out_if and the timer_list_tick_expiry rtl

module tb_top;
  import tle_pkg::*;

  // command code the block must ignore
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // receiver hold-off length for the backpressure test, in cycles
  localparam int HOLD_CYCLES = 200;
  // cycles with no beat on either channel before the run is declared hung
  localparam int STALL_LIMIT = 2000;
  // settle time after the last expected beat: one full sweep plus margin
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [3:0] slot;
    logic       deact;
    logic       last;
  } expiry_t;

  logic clk = 1'b0;
  logic rst_n;

  tle_in_if  in_ch ();
  tle_out_if out_ch ();

  timer_list_tick_expiry uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // model of the slot bank, updated as each command beat is accepted
  // ---------------------------------------------------------------------------
  time_t left_ticks   [NUM_TIMERS] = '{default: '0};
  time_t reload_ticks [NUM_TIMERS] = '{default: '0};
  logic  armed        [NUM_TIMERS] = '{default: 1'b0};
  logic  shot_once    [NUM_TIMERS] = '{default: 1'b0};

  // expiry beats still owed by the block, oldest first
  expiry_t expiry_q [$];

  // set by the tests; burst_mode is read by sender and receiver, hold_pending by the receiver
  logic burst_mode   = 1'b0;  // no idling on either side while set
  logic hold_pending = 1'b0;  // receiver starts a long hold-off when it sees this

  int mismatches    = 0;
  int items_sent    = 0;
  int ticks_sent    = 0;
  int beats_checked = 0;
  int max_burst     = 0;

  function automatic void apply_command(input logic [1:0] cmd, input logic [3:0] slot,
                                        input logic [31:0] ivl, input logic once);
    expiry_t fired [$];
    expiry_t beat;
    case (cmd)
      CMD_ADD: begin
        // add restarts an active slot just the same; interval keeps its low TIME_BITS
        if (slot < NUM_TIMERS) begin
          reload_ticks[slot] = time_t'(ivl);
          left_ticks[slot]   = time_t'(ivl);
          shot_once[slot]    = once;
          armed[slot]        = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (slot < NUM_TIMERS) armed[slot] = 1'b0;
      end
      CMD_TICK: begin
        for (int i = 0; i < SLOT_SPAN; i++) begin
          if (!armed[i]) continue;
          // zero interval wraps to all ones here, so it takes 2^TIME_BITS ticks
          left_ticks[i] = left_ticks[i] - 1'b1;
          if (left_ticks[i] != '0) continue;
          beat.slot  = 4'(i);
          beat.deact = shot_once[i];
          beat.last  = 1'b0;
          if (shot_once[i]) armed[i] = 1'b0;
          else left_ticks[i] = reload_ticks[i];
          fired.push_back(beat);
        end
        if (fired.size() > 0) begin
          fired[fired.size() - 1].last = 1'b1;
          if (fired.size() > max_burst) max_burst = fired.size();
        end
        foreach (fired[k]) expiry_q.push_back(fired[k]);
      end
      default: ;  // unused code: no state change, no beats
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // offer one command beat after a random gap, return once it is taken;
  // valid stays high afterwards so back-to-back beats need no extra edge
  task automatic send_cmd(input logic [1:0] cmd, input logic [3:0] slot,
                          input logic [31:0] ivl, input logic once);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.command  <= cmd;
    in_ch.slot     <= slot;
    in_ch.interval <= ivl;
    in_ch.one_shot <= once;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    apply_command(cmd, slot, ivl, once);
    items_sent++;
    if (cmd == CMD_TICK) ticks_sent++;
  endtask

  // stop offering and wait until every owed expiry beat has arrived
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expiry_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // receiver side: random stall after each beat, plus the long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : sink_side
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        // long hold so the block backs up into its input
        hold_pending = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        stall = burst_mode ? 0 : $urandom_range(0, 15);
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: each expiry beat against the oldest owed one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    expiry_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      beats_checked++;
      if (expiry_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat slot %0d deactivated %0b last %0b", $time,
                 out_ch.expired_slot, out_ch.deactivated, out_ch.last);
      end else begin
        want = expiry_q.pop_front();
        if (out_ch.expired_slot !== want.slot) begin
          mismatches++;
          $display("%0t: expired_slot expected %0d actual %0d", $time, want.slot,
                   out_ch.expired_slot);
        end
        if (out_ch.deactivated !== want.deact) begin
          mismatches++;
          $display("%0t: deactivated (slot %0d) expected %0b actual %0b", $time, want.slot,
                   want.deact, out_ch.deactivated);
        end
        if (out_ch.last !== want.last) begin
          mismatches++;
          $display("%0t: last (slot %0d) expected %0b actual %0b", $time, want.slot,
                   want.last, out_ch.last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: any beat on either channel resets the count
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d expiry beats still owed", $time,
               STALL_LIMIT, expiry_q.size());
      $display("tb_top NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // one-shot expiry deactivates, periodic expiry reloads, remove stops a slot
  task automatic test_expiry_kinds();
    send_cmd(CMD_ADD, 4'd0, 32'd1, 1'b1);
    send_cmd(CMD_ADD, 4'd15, 32'd2, 1'b0);
    send_cmd(CMD_TICK, 4'd0, 32'd0, 1'b0);   // slot 0 fires alone, last set
    send_cmd(CMD_TICK, 4'd0, 32'd0, 1'b0);   // slot 15 fires and reloads
    send_cmd(CMD_REMOVE, 4'd15, 32'd0, 1'b0);
    drain_results();
  endtask

  // interval extremes, remove of an idle slot, unused code, restart of a running slot
  task automatic test_odd_commands();
    send_cmd(CMD_ADD, 4'd3, 32'hFFFF_FFFF, 1'b1);
    send_cmd(CMD_ADD, 4'd4, 32'd0, 1'b0);            // zero interval wraps
    send_cmd(CMD_REMOVE, 4'd7, 32'hFFFF_FFFF, 1'b1); // slot 7 was never armed
    send_cmd(CMD_UNUSED, 4'd5, 32'd1, 1'b1);         // must not arm slot 5
    send_cmd(CMD_ADD, 4'd6, 32'd5, 1'b0);
    send_cmd(CMD_ADD, 4'd6, 32'd1, 1'b1);            // restart with a shorter one-shot
    send_cmd(CMD_TICK, 4'hF, 32'hFFFF_FFFF, 1'b1);   // payload on a tick is noise
    drain_results();
  endtask

  // every slot fires on the same tick; even slots stay armed with interval 1
  task automatic test_full_sweep();
    for (int s = 0; s < 16; s++) send_cmd(CMD_ADD, 4'(s), 32'd1, s[0]);
    send_cmd(CMD_TICK, 4'd0, 32'd0, 1'b0);
    drain_results();
  endtask

  // receiver holds off while ticks keep coming back to back
  task automatic test_output_backpressure();
    burst_mode   = 1'b1;
    hold_pending = 1'b1;
    repeat (5) send_cmd(CMD_TICK, 4'($urandom), $urandom, 1'($urandom));
    burst_mode = 1'b0;
    drain_results();
  endtask

  // mostly ticks and short-interval adds so slots fire often; removes, long
  // and zero intervals and the unused code mixed in; random no-idle stretches
  task automatic test_random_mix(input int count);
    int          pick;
    int          sel;
    logic [1:0]  cmd;
    logic [31:0] ivl;
    for (int i = 0; i < count; i++) begin
      if (i % 20 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      sel  = $urandom_range(0, 19);
      if (pick < 45) cmd = CMD_TICK;
      else if (pick < 85) cmd = CMD_ADD;
      else if (pick < 97) cmd = CMD_REMOVE;
      else cmd = CMD_UNUSED;
      if (sel == 0) ivl = 32'd0;
      else if (sel == 1) ivl = $urandom;
      else ivl = $urandom_range(1, 6);
      send_cmd(cmd, 4'($urandom_range(0, 15)), ivl, 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 24) == 0) drain_results();
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    in_ch.valid    <= 1'b0;
    in_ch.command  <= CMD_TICK;
    in_ch.slot     <= '0;
    in_ch.interval <= '0;
    in_ch.one_shot <= 1'b0;
    rst_n          <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_expiry_kinds();
    test_odd_commands();
    test_full_sweep();
    test_output_backpressure();
    test_random_mix(76);

    // nothing more may come out once the owed beats are in
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d commands including %0d ticks", items_sent, ticks_sent);
    $display("%0d expiry beats checked, at most %0d on one tick, %0d mismatches",
             beats_checked, max_burst, mismatches);
    if (mismatches == 0 && expiry_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      if (expiry_q.size() != 0) $display("%0d expiry beats never arrived", expiry_q.size());
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/tle_pkg.sv
sv/tle_if.sv
sv/tle_ctrl.sv
sv/tle_dp.sv
sv/timer_list_tick_expiry.sv
verif/tb_top.sv
